### src/psccd_pkg.sv
package psccd_pkg;

  localparam int ETA_W     = 17;
  localparam int EPS_W     = 16;
  localparam int ETA_FRAC  = 16;
  localparam int OUT_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS = 2'd1;

  localparam logic [ETA_W-1:0] ETA_RESET = 17'd58982;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // moving vertex codes
  localparam logic [1:0] MV_NONE = 2'd0;
  localparam logic [1:0] MV_NODE = 2'd1;
  localparam logic [1:0] MV_SEG0 = 2'd2;
  localparam logic [1:0] MV_SEG1 = 2'd3;

  // multiplier operand sources
  typedef logic [3:0] src_t;
  localparam src_t SRC_ZERO = 4'd0;
  localparam src_t SRC_X21X = 4'd1;
  localparam src_t SRC_X21Y = 4'd2;
  localparam src_t SRC_X32X = 4'd3;
  localparam src_t SRC_X32Y = 4'd4;
  localparam src_t SRC_RX   = 4'd5;
  localparam src_t SRC_RY   = 4'd6;
  localparam src_t SRC_GX   = 4'd7;
  localparam src_t SRC_GY   = 4'd8;
  localparam src_t SRC_RELX = 4'd9;
  localparam src_t SRC_RELY = 4'd10;
  localparam src_t SRC_SGX  = 4'd11;
  localparam src_t SRC_SGY  = 4'd12;
  localparam src_t SRC_ETA  = 4'd13;
  localparam src_t SRC_TQ   = 4'd14;
  localparam src_t SRC_ONE  = 4'd15;

  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_ADD  = 2'd2;
  localparam acc_op_t ACC_SUB  = 2'd3;

  typedef logic [3:0] dest_t;
  localparam dest_t DST_NONE = 4'd0;
  localparam dest_t DST_B    = 4'd1;
  localparam dest_t DST_C    = 4'd2;
  localparam dest_t DST_RELX = 4'd3;
  localparam dest_t DST_RELY = 4'd4;
  localparam dest_t DST_SGX  = 4'd5;
  localparam dest_t DST_SGY  = 4'd6;
  localparam dest_t DST_LEN2 = 4'd7;
  localparam dest_t DST_DOT  = 4'd8;
  localparam dest_t DST_STP  = 4'd9;

  // op acts on the product issued by the previous step; dst stores the accumulator
  typedef struct packed {
    src_t    a;
    src_t    b;
    acc_op_t op;
    dest_t   dst;
  } mac_cmd_t;

  typedef struct packed {
    logic     load;
    mac_cmd_t mac;
    logic     div_init;
    logic     div_step;
    logic     update;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic root_ok;
    logic out_free;
  } dp_stat_t;

  localparam logic [CNT_W-1:0] COEF_LAST = 5'd7;
  localparam logic [CNT_W-1:0] POS_LAST  = 5'd16;

  function automatic mac_cmd_t mc(src_t a, src_t b, acc_op_t op, dest_t dst);
    mac_cmd_t c;
    c.a   = a;
    c.b   = b;
    c.op  = op;
    c.dst = dst;
    return c;
  endfunction

  // b = g x x21 + x32 x r, then c = x32 x x21
  function automatic mac_cmd_t coef_cmd(logic [CNT_W-1:0] step);
    mac_cmd_t c;
    case (step)
      5'd0:    c = mc(SRC_GX,   SRC_X21Y, ACC_HOLD, DST_NONE);
      5'd1:    c = mc(SRC_GY,   SRC_X21X, ACC_LOAD, DST_NONE);
      5'd2:    c = mc(SRC_X32X, SRC_RY,   ACC_SUB,  DST_NONE);
      5'd3:    c = mc(SRC_X32Y, SRC_RX,   ACC_ADD,  DST_NONE);
      5'd4:    c = mc(SRC_X32X, SRC_X21Y, ACC_SUB,  DST_NONE);
      5'd5:    c = mc(SRC_X32Y, SRC_X21X, ACC_LOAD, DST_B);
      5'd6:    c = mc(SRC_ZERO, SRC_ZERO, ACC_SUB,  DST_NONE);
      5'd7:    c = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_C);
      default: c = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_NONE);
    endcase
    return c;
  endfunction

  // positions at t (base scaled by one, floor on store), then len2, dot, eta*t
  function automatic mac_cmd_t pos_cmd(logic [CNT_W-1:0] step);
    mac_cmd_t c;
    case (step)
      5'd0:    c = mc(SRC_X21X, SRC_ONE,  ACC_HOLD, DST_NONE);
      5'd1:    c = mc(SRC_RX,   SRC_TQ,   ACC_LOAD, DST_NONE);
      5'd2:    c = mc(SRC_X21Y, SRC_ONE,  ACC_ADD,  DST_NONE);
      5'd3:    c = mc(SRC_RY,   SRC_TQ,   ACC_LOAD, DST_RELX);
      5'd4:    c = mc(SRC_X32X, SRC_ONE,  ACC_ADD,  DST_NONE);
      5'd5:    c = mc(SRC_GX,   SRC_TQ,   ACC_LOAD, DST_RELY);
      5'd6:    c = mc(SRC_X32Y, SRC_ONE,  ACC_ADD,  DST_NONE);
      5'd7:    c = mc(SRC_GY,   SRC_TQ,   ACC_LOAD, DST_SGX);
      5'd8:    c = mc(SRC_ZERO, SRC_ZERO, ACC_ADD,  DST_NONE);
      5'd9:    c = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_SGY);
      5'd10:   c = mc(SRC_SGX,  SRC_SGX,  ACC_HOLD, DST_NONE);
      5'd11:   c = mc(SRC_SGY,  SRC_SGY,  ACC_LOAD, DST_NONE);
      5'd12:   c = mc(SRC_RELX, SRC_SGX,  ACC_ADD,  DST_NONE);
      5'd13:   c = mc(SRC_RELY, SRC_SGY,  ACC_LOAD, DST_LEN2);
      5'd14:   c = mc(SRC_ETA,  SRC_TQ,   ACC_ADD,  DST_NONE);
      5'd15:   c = mc(SRC_ZERO, SRC_ZERO, ACC_LOAD, DST_DOT);
      5'd16:   c = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_STP);
      default: c = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_NONE);
    endcase
    return c;
  endfunction

endpackage

### src/point_segment_ccd_safe_step_core.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | node_*, seg0_*, seg1_*, mover, disp_*, last
// out     | output    | out_valid / out_stall | min_step, hit
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each candidate runs the shared multiplier sequence and the bit-serial divide before the
// next accept; a new candidate is not taken until the last one is through.
// Skipped candidates go straight to the final state; rejected roots skip the divide.
// Synchronous active-high reset returns config, running minimum and hit flag to defaults.
// A last beat waits in the final state while the result register is still stalled.
module point_segment_ccd_safe_step_core #(
  parameter int COORD_BITS      = 16,
  parameter int COORD_FRAC_BITS = 8,
  parameter int STEP_FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    node_x,
  input  logic signed [COORD_BITS-1:0]    node_y,
  input  logic signed [COORD_BITS-1:0]    seg0_x,
  input  logic signed [COORD_BITS-1:0]    seg0_y,
  input  logic signed [COORD_BITS-1:0]    seg1_x,
  input  logic signed [COORD_BITS-1:0]    seg1_y,
  input  logic [1:0]                      mover,
  input  logic signed [COORD_BITS-1:0]    disp_x,
  input  logic signed [COORD_BITS-1:0]    disp_y,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psccd_pkg::OUT_W-1:0]     min_step,
  output logic                            hit,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psccd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psccd_pkg::ETA_W-1:0]     cfg_data
);
  import psccd_pkg::*;

  localparam int SFW = STEP_FRAC_BITS + 1;
  localparam logic [SFW-1:0] FULL_STEP = SFW'(1) << STEP_FRAC_BITS;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  psccd_ctrl #(
    .STEP_FRAC_BITS(STEP_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  psccd_datapath #(
    .COORD_BITS      (COORD_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .STEP_FRAC_BITS  (STEP_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .node_x    (node_x),
    .node_y    (node_y),
    .seg0_x    (seg0_x),
    .seg0_y    (seg0_y),
    .seg1_x    (seg1_x),
    .seg1_y    (seg1_y),
    .mover     (mover),
    .disp_x    (disp_x),
    .disp_y    (disp_y),
    .last      (last),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .min_step  (min_step),
    .hit       (hit)
  );

`ifndef SYNTH
  // an accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a query without a hit reports the full step
  a_no_hit_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (min_step == OUT_W'(FULL_STEP)))
    else $error("missed query reports reduced step");

  // a result appears only after the input side has been busy
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without work in flight");
`endif

endmodule

### src/psccd_ctrl.sv
module psccd_ctrl #(
  parameter int STEP_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output psccd_pkg::dp_cmd_t cmd,
  input  psccd_pkg::dp_stat_t stat
);
  import psccd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COEF  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_POS   = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STEP_FRAC_BITS - 1);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    cmd        = '0;
    cmd.mac    = mc(SRC_ZERO, SRC_ZERO, ACC_HOLD, DST_NONE);
    state_next = state;
    cnt_next   = cnt;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_COEF;
          cnt_next   = '0;
        end
      end
      S_COEF: begin
        if (cnt == '0 && stat.skip) begin
          state_next = S_FIN;
        end else begin
          cmd.mac  = coef_cmd(cnt);
          cnt_next = cnt + 1'b1;
          if (cnt == COEF_LAST) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (stat.root_ok) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_POS;
          cnt_next   = '0;
        end
      end
      S_POS: begin
        cmd.mac  = pos_cmd(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == POS_LAST) state_next = S_TEST;
      end
      S_TEST: begin
        cmd.update = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

### src/psccd_datapath.sv
module psccd_datapath #(
  parameter int COORD_BITS      = 16,
  parameter int COORD_FRAC_BITS = 8,
  parameter int STEP_FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  psccd_pkg::dp_cmd_t                   cmd,
  output psccd_pkg::dp_stat_t                  stat,
  input  logic signed [COORD_BITS-1:0]         node_x,
  input  logic signed [COORD_BITS-1:0]         node_y,
  input  logic signed [COORD_BITS-1:0]         seg0_x,
  input  logic signed [COORD_BITS-1:0]         seg0_y,
  input  logic signed [COORD_BITS-1:0]         seg1_x,
  input  logic signed [COORD_BITS-1:0]         seg1_y,
  input  logic [1:0]                           mover,
  input  logic signed [COORD_BITS-1:0]         disp_x,
  input  logic signed [COORD_BITS-1:0]         disp_y,
  input  logic                                 last,
  input  logic                                 cfg_write,
  input  logic [psccd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psccd_pkg::ETA_W-1:0]          cfg_data,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [psccd_pkg::OUT_W-1:0]          min_step,
  output logic                                 hit
);
  import psccd_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int MW0  = (DW + 1 > STEP_FRAC_BITS + 2) ? DW + 1 : STEP_FRAC_BITS + 2;
  localparam int MW   = (MW0 > ETA_W + 1) ? MW0 : ETA_W + 1;
  localparam int AW   = 2 * MW + 2;
  localparam int QW   = STEP_FRAC_BITS + 1;
  localparam int RW   = AW + 1;
  localparam int ESH  = 2 * COORD_FRAC_BITS - 16;
  localparam int SH_L = (ESH >= 0) ? ESH : 0;
  localparam int SH_R = (ESH < 0) ? -ESH : 0;
  localparam int EW   = (AW > EPS_W + SH_L + 1) ? AW : EPS_W + SH_L + 1;

  localparam logic signed [MW-1:0] ONE_SH = MW'(1) << STEP_FRAC_BITS;
  localparam logic [QW-1:0]        FULL   = QW'(1) << STEP_FRAC_BITS;
  localparam logic [EW-1:0]        RND    = EW'((1 << SH_R) - 1);

  // config
  logic [ETA_W-1:0] eta;
  logic [EPS_W-1:0] eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta <= ETA_RESET;
      eps <= EPS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ETA: eta <= cfg_data;
        REG_EPS: eps <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // candidate setup
  logic signed [DW-1:0] dx, dy, dpx, dpy, rx_n, ry_n, gx_n, gy_n;
  logic signed [DW-1:0] x21x, x21y, x32x, x32y, rx, ry, gx, gy;
  logic                 skip, last_r;

  always_comb begin
    dpx  = DW'(disp_x);
    dpy  = DW'(disp_y);
    dx   = -dpx;
    dy   = -dpy;
    rx_n = '0;
    ry_n = '0;
    gx_n = '0;
    gy_n = '0;
    case (mover)
      MV_NODE: begin
        rx_n = dx;
        ry_n = dy;
      end
      MV_SEG0: begin
        rx_n = dpx;
        ry_n = dpy;
        gx_n = dpx;
        gy_n = dpy;
      end
      MV_SEG1: begin
        gx_n = dx;
        gy_n = dy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x21x   <= DW'(node_x) - DW'(seg0_x);
      x21y   <= DW'(node_y) - DW'(seg0_y);
      x32x   <= DW'(seg1_x) - DW'(seg0_x);
      x32y   <= DW'(seg1_y) - DW'(seg0_y);
      rx     <= rx_n;
      ry     <= ry_n;
      gx     <= gx_n;
      gy     <= gy_n;
      skip   <= (mover == MV_NONE);
      last_r <= last;
    end
  end

  // multiply-accumulate
  logic signed [MW-1:0]   relx, rely, sgx, sgy;
  logic [QW-1:0]          tq;
  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] prod;
  logic signed [AW-1:0]   acc, b_r, c_r, len2, dot;
  logic [QW-1:0]          stp;

  function automatic logic signed [MW-1:0] pick(src_t s);
    logic signed [MW-1:0] v;
    case (s)
      SRC_X21X: v = MW'(x21x);
      SRC_X21Y: v = MW'(x21y);
      SRC_X32X: v = MW'(x32x);
      SRC_X32Y: v = MW'(x32y);
      SRC_RX:   v = MW'(rx);
      SRC_RY:   v = MW'(ry);
      SRC_GX:   v = MW'(gx);
      SRC_GY:   v = MW'(gy);
      SRC_RELX: v = relx;
      SRC_RELY: v = rely;
      SRC_SGX:  v = sgx;
      SRC_SGY:  v = sgy;
      SRC_ETA:  v = signed'({{(MW-ETA_W){1'b0}}, eta});
      SRC_TQ:   v = signed'({{(MW-QW){1'b0}}, tq});
      SRC_ONE:  v = ONE_SH;
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a = pick(cmd.mac.a);
    op_b = pick(cmd.mac.b);
  end

  logic [AW-1:0] acc_u, acc_sh;
  logic [QW-1:0] stp_n;

  always_comb begin
    acc_u  = acc;
    acc_sh = acc_u >> ETA_FRAC;
    if (tq == '0) stp_n = '0;
    else if (acc_sh > AW'(FULL)) stp_n = FULL;
    else stp_n = acc_sh[QW-1:0];
  end

  // prod holds the product issued last cycle, so the current op applies to it
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (cmd.mac.op)
      ACC_LOAD: acc <= AW'(prod);
      ACC_ADD:  acc <= acc + AW'(prod);
      ACC_SUB:  acc <= acc - AW'(prod);
      default:  ;
    endcase
    case (cmd.mac.dst)
      DST_B:    b_r  <= acc;
      DST_C:    c_r  <= acc;
      DST_RELX: relx <= MW'(acc >>> STEP_FRAC_BITS);
      DST_RELY: rely <= MW'(acc >>> STEP_FRAC_BITS);
      DST_SGX:  sgx  <= MW'(acc >>> STEP_FRAC_BITS);
      DST_SGY:  sgy  <= MW'(acc >>> STEP_FRAC_BITS);
      DST_LEN2: len2 <= acc;
      DST_DOT:  dot  <= acc;
      DST_STP:  stp  <= stp_n;
      default:  ;
    endcase
  end

  // root checks
  logic [EW-1:0]        thr;
  logic [AW-1:0]        mag_b, num_u, len2_u;
  logic signed [AW-1:0] num;
  logic                 root_ok, hit_ok;

  always_comb begin
    thr     = ((EW'(eps) + RND) >> SH_R) << SH_L;
    mag_b   = b_r[AW-1] ? AW'(-b_r) : AW'(b_r);
    num     = (b_r[AW-1] || b_r == '0) ? c_r : -c_r;
    num_u   = num;
    root_ok = (b_r != '0) && (EW'(mag_b) >= thr) && !num[AW-1] && (num_u <= mag_b);
    len2_u  = len2;
    hit_ok  = (EW'(len2_u) >= thr) && !dot[AW-1] && (dot <= len2);
  end

  // restoring divide, one quotient bit per cycle
  logic [AW-1:0] den;
  logic [RW-1:0] rem, rem2;

  always_comb rem2 = {rem[RW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den <= mag_b;
      if (num_u >= mag_b) begin
        tq  <= QW'(1);
        rem <= RW'(num_u - mag_b);
      end else begin
        tq  <= '0;
        rem <= RW'(num_u);
      end
    end else if (cmd.div_step) begin
      if (rem2 >= RW'(den)) begin
        rem <= rem2 - RW'(den);
        tq  <= {tq[QW-2:0], 1'b1};
      end else begin
        rem <= rem2;
        tq  <= {tq[QW-2:0], 1'b0};
      end
    end
  end

  // query state and result register
  logic [QW-1:0] running_min;
  logic          any_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= FULL;
      any_hit     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        running_min <= FULL;
        any_hit     <= 1'b0;
      end else begin
        if (out_valid && !out_stall) out_valid <= 1'b0;
        if (cmd.update && hit_ok) begin
          any_hit <= 1'b1;
          if (stp < running_min) running_min <= stp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      min_step <= OUT_W'(running_min);
      hit      <= any_hit;
    end
  end

  always_comb begin
    stat.skip     = skip;
    stat.last     = last_r;
    stat.root_ok  = root_ok;
    stat.out_free = !out_valid || !out_stall;
  end

endmodule

### tb/point_segment_ccd_safe_step_core_test.sv
module point_segment_ccd_safe_step_core_test;
  import psccd_pkg::*;

  typedef struct packed {
    logic signed [15:0] node_x;
    logic signed [15:0] node_y;
    logic signed [15:0] seg0_x;
    logic signed [15:0] seg0_y;
    logic signed [15:0] seg1_x;
    logic signed [15:0] seg1_y;
    logic [1:0]         mover;
    logic signed [15:0] disp_x;
    logic signed [15:0] disp_y;
    logic               last;
  } cand_t;

  typedef struct packed {
    logic [16:0] min_step;
    logic        hit;
  } verdict_t;

  localparam logic [1:0] REG_UNUSED = 2'd2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cand_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [16:0] min_step;
  logic hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  point_segment_ccd_safe_step_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .node_x(drv.node_x), .node_y(drv.node_y),
    .seg0_x(drv.seg0_x), .seg0_y(drv.seg0_y),
    .seg1_x(drv.seg1_x), .seg1_y(drv.seg1_y),
    .mover(drv.mover), .disp_x(drv.disp_x), .disp_y(drv.disp_y), .last(drv.last),
    .out_valid(out_valid), .out_stall(out_stall),
    .min_step(min_step), .hit(hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [16:0] m_eta = ETA_RESET;
  logic [15:0] m_eps = EPS_RESET;
  longint m_min = 65536;
  bit m_hit = 1'b0;

  cand_t pending[$];
  verdict_t expected_q[$];
  int errors = 0;
  int mismatches = 0;
  bit sender_hold = 1'b0;
  int recv_hold = 0;

  function automatic longint floor16(longint v);
    return v >>> 16;  // arithmetic shift floors
  endfunction

  function automatic void predict_candidate(cand_t it);
    longint px, py, ax, ay, bx, by, dx, dy, x21x, x21y, x32x, x32y;
    longint rx, ry, gx, gy, b, c, num, den, tq, rem, relx, rely, sgx, sgy;
    longint len2, dot, stp, thr;
    verdict_t v;
    rx = 0; ry = 0; gx = 0; gy = 0;
    thr = m_eps;
    if (it.mover != MV_NONE) begin
      px = it.node_x; py = it.node_y; ax = it.seg0_x; ay = it.seg0_y;
      bx = it.seg1_x; by = it.seg1_y;
      dx = -longint'(it.disp_x); dy = -longint'(it.disp_y);
      x21x = px - ax; x21y = py - ay; x32x = bx - ax; x32y = by - ay;
      case (it.mover)
        MV_NODE: begin rx = dx; ry = dy; end
        MV_SEG0: begin rx = -dx; ry = -dy; gx = -dx; gy = -dy; end
        default: begin gx = dx; gy = dy; end
      endcase
      b = (gx * x21y - gy * x21x) + (x32x * ry - x32y * rx);
      c = x32x * x21y - x32y * x21x;
      if (b != 0 && (b < 0 ? -b : b) >= thr) begin
        if (b > 0) begin num = -c; den = b; end
        else begin num = c; den = -b; end
        if (num >= 0 && num <= den) begin
          tq = 0; rem = num;
          if (rem >= den) begin tq = 1; rem -= den; end
          for (int i = 0; i < 16; i++) begin
            rem <<= 1; tq <<= 1;
            if (rem >= den) begin rem -= den; tq |= 1; end
          end
          relx = x21x + floor16(rx * tq);
          rely = x21y + floor16(ry * tq);
          sgx = x32x + floor16(gx * tq);
          sgy = x32y + floor16(gy * tq);
          len2 = sgx * sgx + sgy * sgy;
          dot = relx * sgx + rely * sgy;
          if (len2 >= thr && dot >= 0 && dot <= len2) begin
            stp = 0;
            if (tq != 0) begin
              stp = (longint'(m_eta) * tq) >> 16;
              if (stp > 65536) stp = 65536;
            end
            m_hit = 1'b1;
            if (stp < m_min) m_min = stp;
          end
        end
      end
    end
    if (it.last) begin
      v.min_step = m_min[16:0];
      v.hit = m_hit;
      expected_q.push_back(v);
      m_min = 65536;
      m_hit = 1'b0;
    end
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_candidate(drv);
      if (in_valid && in_stall) begin
        // beat held
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending.size() > 0 && !sender_hold) begin
        drv <= pending.pop_front();
        in_valid <= 1'b1;
        gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int rwait = 0;
  always @(posedge clk) begin
    verdict_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %0d/%0d", min_step, hit);
        end else begin
          e = expected_q.pop_front();
          if (e.min_step !== min_step || e.hit !== hit) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp step %0d hit %0d, got step %0d hit %0d",
                       e.min_step, e.hit, min_step, hit);
          end
        end
        rwait <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
        out_stall <= 1'b1;
      end else if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_stall <= 1'b1;
      end else if (rwait > 0) begin
        rwait <= rwait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] rcoord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cand_t rand_cand(bit is_last);
    cand_t c;
    int s;
    c.node_x = rcoord(); c.node_y = rcoord();
    c.seg0_x = rcoord(); c.seg0_y = rcoord();
    c.seg1_x = rcoord(); c.seg1_y = rcoord();
    c.mover = $urandom_range(0, 9) == 0 ? MV_NONE : 2'($urandom_range(1, 3));
    c.disp_x = rcoord(); c.disp_y = rcoord();
    // half the time: point on the line through the segment crossing it at some t
    if ($urandom_range(0, 1) != 0) begin
      s = int'($urandom_range(0, 4));
      c.seg0_x = 16'(int'($urandom_range(0, 4000)) - 2000);
      c.seg0_y = 16'(int'($urandom_range(0, 4000)) - 2000);
      c.seg1_x = 16'(int'(c.seg0_x) + int'($urandom_range(0, 4000)) - 2000);
      c.seg1_y = 16'(int'(c.seg0_y) + int'($urandom_range(0, 4000)) - 2000);
      c.node_x = 16'((int'(c.seg0_x) * s + int'(c.seg1_x) * (4 - s)) / 4);
      c.node_y = 16'((int'(c.seg0_y) * s + int'(c.seg1_y) * (4 - s)) / 4);
      c.disp_x = 16'(int'($urandom_range(0, 4000)) - 2000);
      c.disp_y = 16'(int'($urandom_range(0, 4000)) - 2000);
      c.node_x = 16'(int'(c.node_x) + int'(c.disp_y) / 2);
      c.node_y = 16'(int'(c.node_y) - int'(c.disp_x) / 2);
    end
    c.last = is_last;
    return c;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ETA) m_eta = val;
    else if (idx == REG_EPS) m_eps = val[15:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic cand_t mk(logic signed [15:0] nx, ny, ax, ay, bx, by,
                               logic [1:0] mv, logic signed [15:0] ddx, ddy, bit l);
    cand_t c;
    c = '{nx, ny, ax, ay, bx, by, mv, ddx, ddy, l};
    return c;
  endfunction

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: point crossing segment, each mover, degenerate cases
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, 512, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_SEG0, 0, -512, 0));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_SEG1, 0, -512, 1));
    pending.push_back(mk(0, 0, -256, 0, 256, 0, MV_NODE, 0, 256, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NONE, 0, 512, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 256, 0, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, -512, 1));
    pending.push_back(mk(0, 256, 0, 0, 0, 0, MV_NODE, 0, 512, 1));
    pending.push_back(mk(1024, 256, -256, 0, 256, 0, MV_NODE, 0, 512, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, 256, 1));
    pending.push_back(mk(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                         MV_SEG1, 16'sh8000, 16'sh8000, 0));
    pending.push_back(mk(16'sh8000, 16'sh7fff, 0, 0, 16'sh8000, 16'sh8000,
                         MV_NODE, 16'sh7fff, 16'sh8000, 1));
    drain();
    cfg_write(REG_ETA, 17'd65536);
    cfg_write(REG_EPS, 17'd0);
    cfg_write(REG_UNUSED, 17'h1ffff);
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, 512, 1));
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, 256, 1));
    drain();
    cfg_write(REG_ETA, 17'h1ffff);
    cfg_write(REG_EPS, 17'hffff);
    pending.push_back(mk(0, 256, -256, 0, 256, 0, MV_NODE, 0, 512, 1));
    pending.push_back(mk(0, 256, -32768, 0, 32767, 0, MV_NODE, 0, 512, 1));
    drain();
    // random phases over several register settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin cfg_write(REG_ETA, 17'd0); cfg_write(REG_EPS, 17'd1); end
        1: begin
          cfg_write(REG_ETA, 17'($urandom_range(0, 131071)));
          cfg_write(REG_EPS, 17'($urandom_range(0, 65535)));
        end
        2: begin
          cfg_write(REG_ETA, ETA_RESET);
          cfg_write(REG_EPS, 17'($urandom_range(0, 64)));
        end
        default: begin
          cfg_write(REG_ETA, 17'($urandom_range(30000, 70000)));
          cfg_write(REG_EPS, 17'd0);
        end
      endcase
      n = 0;
      while (n < 400) begin
        pending.push_back(rand_cand($urandom_range(0, 3) == 0));
        n++;
      end
      pending.push_back(rand_cand(1'b1));
      if (ph == 1) begin
        while (pending.size() > 300) @(posedge clk);
        recv_hold <= 400;  // long receiver stall, sender keeps going
      end
      if (ph == 2) begin
        while (pending.size() > 200) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_q.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
